// ===== rtl/h264sps_pkg.sv =====
// ----------------------------------------------------------------------------
// h264sps_pkg
// Shared types and constants of the SPS parser: queue item, status codes,
// read kinds, back-end states, syntax steps and the high-profile test.
// ----------------------------------------------------------------------------
package h264sps_pkg;

    typedef struct packed {
        logic [7:0] data;
        logic       feed;
        logic       last;
        logic       too_short;
    } t_item;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_BITS  = 3'd2,
        ST_POC   = 3'd3,
        ST_CROP  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RD_FIX = 2'd0,
        RD_PRE = 2'd1,
        RD_SUF = 2'd2
    } t_rd_kind;

    typedef enum logic [1:0] {
        BK_RUN = 2'd0,
        BK_FIN = 2'd1,
        BK_OUT = 2'd2
    } t_bk_state;

    typedef enum logic [6:0] {
        S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_SEPPLANE, S_DEPTHL,
        S_DEPTHC, S_BYPASS, S_SMPRESENT, S_LISTFLAG, S_DELTA, S_FRAMENUM,
        S_POCTYPE, S_POCLSB, S_DZERO, S_OFFNR, S_OFFTB, S_CYCLE, S_OFFREF,
        S_NUMREF, S_GAPS, S_WIDTH, S_HEIGHT, S_FMO, S_MBAFF, S_DIRECT,
        S_CROPFLAG, S_CL, S_CR, S_CT, S_CB, S_VUIFLAG, S_ARFLAG, S_ARIDC,
        S_SAR, S_OVFLAG, S_OVAPPR, S_VSTFLAG, S_VFMT, S_CDFLAG, S_CD,
        S_CLFLAG, S_CLT, S_CLB, S_TIMFLAG, S_TIM, S_NALFLAG, S_VCLFLAG,
        S_HCNT, S_HSCALE, S_HBR, S_HCS, S_HCBR, S_HTAIL, S_LOWDELAY, S_TAIL2,
        S_DONE
    } t_step;

    localparam logic [7:0] EP_BYTE     = 8'h03;
    localparam logic [7:0] SAR_EXTENDED = 8'd255;

    // Profiles that carry chroma format, bit depth and scaling lists.
    function automatic logic is_high(input logic [7:0] p);
        is_high = p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83,
                            8'd86, 8'd118, 8'd128, 8'd138, 8'd144};
    endfunction

endpackage

// ===== rtl/h264sps_front.sv =====
// ----------------------------------------------------------------------------
// h264sps_front
// Byte intake: tags each byte for the parser queue, marking the header byte
// and emulation-prevention bytes so that the parser skips them.
// ----------------------------------------------------------------------------
module h264sps_front
    import h264sps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    input  logic [7:0] i_tdata,
    input  logic       i_tlast,
    output logic       o_tready,
    input  logic       i_full,
    output logic       o_push,
    output t_item      o_item
);

    logic [2:0] r_byte_count, n_byte_count;
    logic [1:0] r_zero_run,   n_zero_run;
    logic       is_ep;

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;
    assign is_ep    = (r_zero_run == 2'd2) && (i_tdata == EP_BYTE);

    always_comb begin
        o_item.data      = i_tdata;
        o_item.feed      = (r_byte_count != 3'd0) && !is_ep;
        o_item.last      = i_tlast;
        o_item.too_short = r_byte_count < 3'd3;
        n_byte_count     = r_byte_count;
        n_zero_run       = r_zero_run;
        if (o_push) begin
            if (r_byte_count < 3'd4) begin
                n_byte_count = r_byte_count + 3'd1;
            end
            if (is_ep) begin
                n_zero_run = 2'd0;
            end else if (i_tdata == 8'd0) begin
                if (r_zero_run != 2'd2) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else begin
                n_zero_run = 2'd0;
            end
            if (i_tlast) begin
                n_byte_count = 3'd0;
                n_zero_run   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 3'd0;
            r_zero_run   <= 2'd0;
        end else begin
            r_byte_count <= n_byte_count;
            r_zero_run   <= n_zero_run;
        end
    end

endmodule

// ===== rtl/h264sps_fifo.sv =====
// ----------------------------------------------------------------------------
// h264sps_fifo
// Small item queue between intake and parser, head shown combinationally.
// ----------------------------------------------------------------------------
module h264sps_fifo
    import h264sps_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count beyond depth");
    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full) else $error("full queue lost an item");
`endif

endmodule

// ===== rtl/h264sps_back.sv =====
// ----------------------------------------------------------------------------
// h264sps_back
// Bit-serial SPS syntax walker with fixed and Exp-Golomb reads, final crop
// arithmetic and the result register.
// ----------------------------------------------------------------------------
module h264sps_back
    import h264sps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_item        i_head,
    input  logic         i_empty,
    output logic         o_pop,
    output logic         o_tvalid,
    output logic [207:0] o_tdata,
    output logic [7:0]   o_tuser,
    input  logic         i_tready
);

    t_bk_state   r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_short, n_short;
    t_step       r_step, n_step;
    t_rd_kind    r_kind, n_kind;
    logic [6:0]  r_left, n_left;
    logic [5:0]  r_zeros, n_zeros;
    logic [31:0] r_gv, n_gv;
    logic [31:0] r_loop, n_loop;
    logic [3:0]  r_li, n_li;
    logic [7:0]  r_slast, n_slast, r_snext, n_snext;
    t_status     r_failed, n_failed;
    logic [2:0]  r_hrd, n_hrd;
    logic [7:0]  r_prof, n_prof, r_constr, n_constr, r_level, n_level;
    logic [7:0]  r_luma, n_luma, r_cdep, n_cdep;
    logic [1:0]  r_poc, n_poc;
    logic        r_fmo, n_fmo;
    logic [31:0] r_setid, n_setid, r_chroma, n_chroma, r_fnum, n_fnum;
    logic [31:0] r_w, n_w, r_h, n_h;
    logic [31:0] r_cl, n_cl, r_cr, n_cr, r_ct, n_ct, r_cb, n_cb;
    logic [31:0] r_cw, n_cw, r_ch, n_ch, r_crw, n_crw, r_crh, n_crh;
    logic        r_ovalid, n_ovalid;
    logic [207:0] r_odata, n_odata;
    t_status     r_ostat, n_ostat;

    logic        bit_en, b, adv, go, ue, ld_more;
    logic [31:0] v, sh, lc, wp1, hp1;
    logic [6:0]  len;
    t_step       tgt;
    logic [3:0]  li1, lim;
    logic [7:0]  dh, d, sn;
    logic [1:0]  sy;
    t_status     st;

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = {5'd0, r_ostat};

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;     n_short = r_short;
        n_step = r_step;     n_kind = r_kind;   n_left = r_left;
        n_zeros = r_zeros;   n_gv = r_gv;       n_loop = r_loop;
        n_li = r_li;         n_slast = r_slast; n_snext = r_snext;
        n_failed = r_failed; n_hrd = r_hrd;
        n_prof = r_prof;     n_constr = r_constr; n_level = r_level;
        n_luma = r_luma;     n_cdep = r_cdep;   n_poc = r_poc;  n_fmo = r_fmo;
        n_setid = r_setid;   n_chroma = r_chroma; n_fnum = r_fnum;
        n_w = r_w;           n_h = r_h;
        n_cl = r_cl;         n_cr = r_cr;       n_ct = r_ct;    n_cb = r_cb;
        n_cw = r_cw;         n_ch = r_ch;       n_crw = r_crw;  n_crh = r_crh;
        n_ovalid = r_ovalid && !i_tready;
        n_odata = r_odata;   n_ostat = r_ostat;
        o_pop = 1'b0;
        bit_en = 1'b0;
        adv = 1'b0; go = 1'b0; ue = 1'b0; len = 7'd1; tgt = S_DONE; v = '0;
        b   = i_head.data[3'd7 - r_cnt];
        sh  = {r_gv[30:0], b};
        lc  = r_loop - 32'd1;
        li1 = r_li + 4'd1;
        lim = (r_chroma == 32'd3) ? 4'd12 : 4'd8;
        ld_more = li1 < lim;
        dh  = '0; d = '0; sn = '0;
        wp1 = r_w + 32'd1;
        hp1 = r_h + 32'd1;
        sy  = {1'b0, !r_fmo} + {1'b0, r_chroma == 32'd1};
        st  = ST_OK;

        case (r_state)
            BK_RUN: begin
                if (!i_empty) begin
                    if (i_head.feed) begin
                        bit_en = 1'b1;
                        n_cnt  = r_cnt + 3'd1;
                        if (r_cnt == 3'd7) begin
                            o_pop = 1'b1;
                            if (i_head.last) begin
                                n_short = i_head.too_short;
                                n_state = BK_FIN;
                            end
                        end
                    end else begin
                        o_pop = 1'b1;
                        if (i_head.last) begin
                            n_short = i_head.too_short;
                            n_state = BK_FIN;
                        end
                    end
                end
            end
            BK_FIN: begin
                n_cw    = {wp1[27:0], 4'd0};
                n_ch    = r_fmo ? {hp1[27:0], 4'd0} : {hp1[26:0], 5'd0};
                n_crw   = ((r_chroma == 32'd0) || (r_chroma == 32'd3)) ?
                          (r_cl + r_cr) : ((r_cl + r_cr) << 1);
                n_crh   = (r_ct + r_cb) << sy;
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (!r_ovalid || i_tready) begin
                    if (r_short) begin
                        st = ST_SHORT;
                    end else if (r_failed != ST_OK) begin
                        st = r_failed;
                    end else if (r_step != S_DONE) begin
                        st = ST_BITS;
                    end else if ((r_crw >= r_cw) || (r_crh >= r_ch)) begin
                        st = ST_CROP;
                    end
                    n_ovalid = 1'b1;
                    n_ostat  = st;
                    n_odata  = '0;
                    if (st == ST_OK) begin
                        n_odata = {6'd0, r_ch - r_crh, r_cw - r_crw, r_fnum, r_poc,
                                   r_cdep + 8'd8, r_luma + 8'd8, r_chroma,
                                   r_setid, r_level, r_constr, r_prof};
                    end
                    n_state = BK_RUN;
                    n_step = S_PROFILE; n_kind = RD_FIX; n_left = 7'd8;
                    n_zeros = '0; n_gv = '0; n_loop = '0; n_li = '0;
                    n_slast = 8'd8; n_snext = 8'd8; n_failed = ST_OK; n_hrd = '0;
                    n_prof = '0; n_constr = '0; n_level = '0; n_luma = '0;
                    n_cdep = '0; n_poc = '0; n_fmo = 1'b0; n_setid = '0;
                    n_chroma = 32'd1; n_fnum = '0; n_w = '0; n_h = '0;
                    n_cl = '0; n_cr = '0; n_ct = '0; n_cb = '0;
                end
            end
            default: n_state = BK_RUN;
        endcase

        if (bit_en && (r_step != S_DONE) && (r_failed == ST_OK)) begin
            case (r_kind)
                RD_FIX: begin
                    n_gv   = sh;
                    n_left = r_left - 7'd1;
                    if (r_left == 7'd1) begin
                        adv = 1'b1;
                        v   = sh;
                    end
                end
                RD_PRE: begin
                    if (!b) begin
                        n_zeros = r_zeros + 6'd1;
                        if (r_zeros >= 6'd31) begin
                            n_failed = ST_BITS;
                        end
                    end else if (r_zeros == 6'd0) begin
                        adv = 1'b1;
                    end else begin
                        n_kind = RD_SUF;
                        n_left = {1'b0, r_zeros};
                        n_gv   = '0;
                    end
                end
                RD_SUF: begin
                    n_gv   = sh;
                    n_left = r_left - 7'd1;
                    if (r_left == 7'd1) begin
                        adv = 1'b1;
                        v   = 32'((33'd1 << r_zeros) - 33'd1) + sh;
                    end
                end
                default: ;
            endcase
        end

        if (adv) begin
            go = 1'b1;
            case (r_step)
                S_PROFILE: begin n_prof = v[7:0]; tgt = S_CONSTR; len = 7'd8; end
                S_CONSTR: begin n_constr = v[7:0]; tgt = S_LEVEL; len = 7'd8; end
                S_LEVEL: begin n_level = v[7:0]; tgt = S_SPSID; ue = 1'b1; end
                S_SPSID: begin
                    n_setid = v;
                    tgt = is_high(r_prof) ? S_CHROMA : S_FRAMENUM;
                    ue  = 1'b1;
                end
                S_CHROMA: begin
                    n_chroma = v;
                    if (v == 32'd3) tgt = S_SEPPLANE;
                    else begin tgt = S_DEPTHL; ue = 1'b1; end
                end
                S_SEPPLANE: begin tgt = S_DEPTHL; ue = 1'b1; end
                S_DEPTHL: begin n_luma = v[7:0]; tgt = S_DEPTHC; ue = 1'b1; end
                S_DEPTHC: begin n_cdep = v[7:0]; tgt = S_BYPASS; end
                S_BYPASS: tgt = S_SMPRESENT;
                S_SMPRESENT: begin
                    if (v[0]) begin n_li = '0; tgt = S_LISTFLAG; end
                    else begin tgt = S_FRAMENUM; ue = 1'b1; end
                end
                S_LISTFLAG: begin
                    if (v[0]) begin
                        n_loop  = (r_li < 4'd6) ? 32'd16 : 32'd64;
                        n_slast = 8'd8;
                        n_snext = 8'd8;
                        tgt = S_DELTA; ue = 1'b1;
                    end else begin
                        n_li = li1;
                        if (ld_more) tgt = S_LISTFLAG;
                        else begin tgt = S_FRAMENUM; ue = 1'b1; end
                    end
                end
                S_DELTA: begin
                    dh = v[8:1];
                    d  = v[0] ? dh + 8'd1 : 8'd0 - dh;
                    sn = r_slast + d;
                    n_snext = sn;
                    if (sn != 8'd0) n_slast = sn;
                    n_loop = lc;
                    if ((sn == 8'd0) || (lc == 32'd0)) begin
                        n_li = li1;
                        if (ld_more) tgt = S_LISTFLAG;
                        else begin tgt = S_FRAMENUM; ue = 1'b1; end
                    end else begin
                        tgt = S_DELTA; ue = 1'b1;
                    end
                end
                S_FRAMENUM: begin n_fnum = v; tgt = S_POCTYPE; ue = 1'b1; end
                S_POCTYPE: begin
                    n_poc = v[1:0];
                    if (v == 32'd0) begin tgt = S_POCLSB; ue = 1'b1; end
                    else if (v == 32'd1) tgt = S_DZERO;
                    else if (v == 32'd2) begin tgt = S_NUMREF; ue = 1'b1; end
                    else begin go = 1'b0; n_failed = ST_POC; end
                end
                S_POCLSB: begin tgt = S_NUMREF; ue = 1'b1; end
                S_DZERO: begin tgt = S_OFFNR; ue = 1'b1; end
                S_OFFNR: begin tgt = S_OFFTB; ue = 1'b1; end
                S_OFFTB: begin tgt = S_CYCLE; ue = 1'b1; end
                S_CYCLE: begin
                    n_loop = v;
                    tgt = (v == 32'd0) ? S_NUMREF : S_OFFREF;
                    ue  = 1'b1;
                end
                S_OFFREF: begin
                    n_loop = lc;
                    tgt = (lc == 32'd0) ? S_NUMREF : S_OFFREF;
                    ue  = 1'b1;
                end
                S_NUMREF: tgt = S_GAPS;
                S_GAPS: begin tgt = S_WIDTH; ue = 1'b1; end
                S_WIDTH: begin n_w = v; tgt = S_HEIGHT; ue = 1'b1; end
                S_HEIGHT: begin n_h = v; tgt = S_FMO; end
                S_FMO: begin n_fmo = v[0]; tgt = v[0] ? S_DIRECT : S_MBAFF; end
                S_MBAFF: tgt = S_DIRECT;
                S_DIRECT: tgt = S_CROPFLAG;
                S_CROPFLAG: begin
                    if (v[0]) begin tgt = S_CL; ue = 1'b1; end
                    else tgt = S_VUIFLAG;
                end
                S_CL: begin n_cl = v; tgt = S_CR; ue = 1'b1; end
                S_CR: begin n_cr = v; tgt = S_CT; ue = 1'b1; end
                S_CT: begin n_ct = v; tgt = S_CB; ue = 1'b1; end
                S_CB: begin n_cb = v; tgt = S_VUIFLAG; end
                S_VUIFLAG: tgt = v[0] ? S_ARFLAG : S_DONE;
                S_ARFLAG: begin
                    if (v[0]) begin tgt = S_ARIDC; len = 7'd8; end
                    else tgt = S_OVFLAG;
                end
                S_ARIDC: begin
                    if (v[7:0] == SAR_EXTENDED) begin tgt = S_SAR; len = 7'd32; end
                    else tgt = S_OVFLAG;
                end
                S_SAR: tgt = S_OVFLAG;
                S_OVFLAG: tgt = v[0] ? S_OVAPPR : S_VSTFLAG;
                S_OVAPPR: tgt = S_VSTFLAG;
                S_VSTFLAG: begin
                    if (v[0]) begin tgt = S_VFMT; len = 7'd4; end
                    else tgt = S_CLFLAG;
                end
                S_VFMT: tgt = S_CDFLAG;
                S_CDFLAG: begin
                    if (v[0]) begin tgt = S_CD; len = 7'd24; end
                    else tgt = S_CLFLAG;
                end
                S_CD: tgt = S_CLFLAG;
                S_CLFLAG: begin
                    if (v[0]) begin tgt = S_CLT; ue = 1'b1; end
                    else tgt = S_TIMFLAG;
                end
                S_CLT: begin tgt = S_CLB; ue = 1'b1; end
                S_CLB: tgt = S_TIMFLAG;
                S_TIMFLAG: begin
                    if (v[0]) begin tgt = S_TIM; len = 7'd65; end
                    else tgt = S_NALFLAG;
                end
                S_TIM: tgt = S_NALFLAG;
                S_NALFLAG: begin
                    if (v[0]) begin n_hrd = r_hrd | 3'b001; tgt = S_HCNT; ue = 1'b1; end
                    else tgt = S_VCLFLAG;
                end
                S_VCLFLAG: begin
                    if (v[0]) begin n_hrd = r_hrd | 3'b110; tgt = S_HCNT; ue = 1'b1; end
                    else if (r_hrd[1:0] != 2'd0) tgt = S_LOWDELAY;
                    else begin tgt = S_TAIL2; len = 7'd2; end
                end
                S_HCNT: begin n_loop = v + 32'd1; tgt = S_HSCALE; len = 7'd8; end
                S_HSCALE: begin tgt = S_HBR; ue = 1'b1; end
                S_HBR: begin tgt = S_HCS; ue = 1'b1; end
                S_HCS: tgt = S_HCBR;
                S_HCBR: begin
                    n_loop = lc;
                    if (lc != 32'd0) begin tgt = S_HBR; ue = 1'b1; end
                    else begin tgt = S_HTAIL; len = 7'd20; end
                end
                S_HTAIL: begin
                    if (!r_hrd[2]) tgt = S_VCLFLAG;
                    else if (r_hrd[1:0] != 2'd0) tgt = S_LOWDELAY;
                    else begin tgt = S_TAIL2; len = 7'd2; end
                end
                S_LOWDELAY: begin tgt = S_TAIL2; len = 7'd2; end
                S_TAIL2: tgt = S_DONE;
                default: tgt = S_DONE;
            endcase
            if (go) begin
                n_step = tgt;
                n_gv   = '0;
                if (ue) begin
                    n_kind  = RD_PRE;
                    n_zeros = '0;
                end else begin
                    n_kind = RD_FIX;
                    n_left = len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;   r_cnt <= '0;      r_short <= 1'b0;
            r_step <= S_PROFILE; r_kind <= RD_FIX; r_left <= 7'd8;
            r_zeros <= '0;       r_gv <= '0;       r_loop <= '0;
            r_li <= '0;          r_slast <= 8'd8;  r_snext <= 8'd8;
            r_failed <= ST_OK;   r_hrd <= '0;
            r_prof <= '0;  r_constr <= '0; r_level <= '0; r_luma <= '0;
            r_cdep <= '0;  r_poc <= '0;    r_fmo <= 1'b0; r_setid <= '0;
            r_chroma <= 32'd1;  r_fnum <= '0; r_w <= '0;  r_h <= '0;
            r_cl <= '0;    r_cr <= '0;     r_ct <= '0;    r_cb <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;   r_cnt <= n_cnt;     r_short <= n_short;
            r_step <= n_step;     r_kind <= n_kind;   r_left <= n_left;
            r_zeros <= n_zeros;   r_gv <= n_gv;       r_loop <= n_loop;
            r_li <= n_li;         r_slast <= n_slast; r_snext <= n_snext;
            r_failed <= n_failed; r_hrd <= n_hrd;
            r_prof <= n_prof;  r_constr <= n_constr; r_level <= n_level;
            r_luma <= n_luma;  r_cdep <= n_cdep;     r_poc <= n_poc;
            r_fmo <= n_fmo;    r_setid <= n_setid;   r_chroma <= n_chroma;
            r_fnum <= n_fnum;  r_w <= n_w;           r_h <= n_h;
            r_cl <= n_cl;      r_cr <= n_cr;         r_ct <= n_ct;  r_cb <= n_cb;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw <= n_cw;   r_ch <= n_ch;   r_crw <= n_crw;   r_crh <= n_crh;
        r_odata <= n_odata;   r_ostat <= n_ostat;
    end

`ifndef SYNTHESIS
    a_bitcnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_RUN) |-> (r_cnt == 3'd0))
        else $error("bit counter active outside the bit walk");
    a_fin_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FIN) |=> (r_state == BK_OUT))
        else $error("crop stage not followed by result stage");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostat != ST_OK)) |-> (r_odata == '0))
        else $error("failed result carries field values");
    a_no_pop_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_RUN) |-> !o_pop)
        else $error("queue popped while finishing a payload");
`endif

endmodule

// ===== rtl/h264_sps_parser.sv =====
// ----------------------------------------------------------------------------
// h264_sps_parser
// H.264 sequence parameter set parser, one payload byte per input item and
// one result item per payload.
// ----------------------------------------------------------------------------
// Each input item is one raw byte of an SPS NAL payload, header byte first,
// with tlast on the final byte. The intake stage marks the header byte and
// emulation-prevention bytes to be skipped and queues every byte; the parser
// walks the SPS syntax one bit per clock while the queue holds a byte, and
// pops skipped bytes without reading them. Intake accepts a byte in any cycle
// while the queue has room, so bursts enter back to back until it is full.
// After the last byte the parser does the crop arithmetic, then sets the
// status and loads the result register when free; the next payload's bytes are
// already being queued meanwhile. The result tuser carries the status code:
// 0 ok, 1 fewer than four bytes, 2 bits ran out, 3 bad picture order count
// type, 4 bad crop. On any nonzero status every data field is zero.
// ----------------------------------------------------------------------------
module h264_sps_parser
    import h264sps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    // tdata: payload_byte[7:0]
    input  logic [7:0]   i_s_tdata,
    input  logic         i_s_tlast,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    // tdata: profile[7:0], constraint_bits[15:8], level[23:16],
    // set_id[55:24], chroma_format[87:56], luma_depth[95:88],
    // chroma_depth[103:96], poc_type[105:104], frame_num_log2_minus4[137:106],
    // picture_width[169:138], picture_height[201:170], zero fill above
    output logic [207:0] o_m_tdata,
    // tuser: status[2:0], zero fill above
    output logic [7:0]   o_m_tuser,
    input  logic         i_m_tready
);

    t_item push_item, head;
    logic  push, pop, empty, full;

    // Intake: header and emulation-prevention skip marks, short-payload tag.
    h264sps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .o_tready (o_s_tready),
        .i_full   (full),
        .o_push   (push),
        .o_item   (push_item)
    );

    // The queue lets intake keep taking bytes while the parser is busy.
    h264sps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // Bit-serial syntax walker and result register.
    h264sps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .i_tready (i_m_tready)
    );

endmodule

// ===== sim/tb_h264_sps_parser.sv =====
// ----------------------------------------------------------------------------
// tb_h264_sps_parser
// Self-checking testbench of the SPS parser: a bit-exact predictor in a
// scoreboard class, generated SPS payloads and random noise, random idling.
// ----------------------------------------------------------------------------
// The sender builds SPS payloads bit by bit from random syntax choices
// (high profiles, scaling lists, all picture order count types, cropping,
// VUI with HRD), adds emulation-prevention bytes and sometimes truncates,
// corrupts or pads them. Noise payloads of random bytes fill the rest. Every
// accepted byte goes through the predictor; every result item is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_h264_sps_parser
    import h264sps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result item: status and the eleven data fields in
    // tdata order.
    typedef struct {
        t_status     status;
        logic [31:0] vals[11];
    } t_sps_result;

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of the parser state, fed with every accepted
    // byte, and the queue of results still to come.
    // ------------------------------------------------------------------------
    class sps_scoreboard;
        int unsigned FIELD_LO[11] = '{0, 8, 16, 24, 56, 88, 96, 104, 106, 138, 170};
        int unsigned FIELD_W[11]  = '{8, 8, 8, 32, 32, 8, 8, 2, 32, 32, 32};
        string       FIELD_NAME[11] = '{"profile", "constraint_bits", "level", "set_id",
            "chroma_format", "luma_depth", "chroma_depth", "poc_type",
            "frame_num_log2_minus4", "picture_width", "picture_height"};

        t_sps_result pending[$];
        int unsigned mismatches;
        int unsigned status_seen[5];

        // Parser state.
        logic [1:0]  zero_run;
        logic [2:0]  byte_count;
        t_step       step;
        t_rd_kind    rd_kind;
        int unsigned rd_left;
        logic [5:0]  zeros;
        logic [31:0] acc;
        logic [31:0] loop_cnt;
        logic [3:0]  list_idx;
        logic [7:0]  scale_last, scale_next;
        logic [2:0]  failed;
        logic [2:0]  hrd;
        logic [31:0] profile, constr, level, set_id, chroma, luma8, chroma8;
        logic [31:0] poc, frame_num, width, height, fmo, crop_l, crop_r, crop_t, crop_b;

        function new();
            mismatches = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            start_payload();
        endfunction

        function void start_payload();
            zero_run = 0; byte_count = 0; zeros = 0; acc = 0; loop_cnt = 0;
            list_idx = 0; scale_last = 8; scale_next = 8; failed = ST_OK; hrd = 0;
            {profile, constr, level, set_id, luma8, chroma8, poc, frame_num} = '0;
            {width, height, fmo, crop_l, crop_r, crop_t, crop_b} = '0;
            chroma = 1;
            step = S_PROFILE; rd_kind = RD_FIX; rd_left = 8;
        endfunction

        function void want_fixed(t_step s, int unsigned n);
            step = s; rd_kind = RD_FIX; rd_left = n; acc = 0;
        endfunction

        function void want_ue(t_step s);
            step = s; rd_kind = RD_PRE; zeros = 0; acc = 0;
        endfunction

        function bit high_profile(logic [7:0] p);
            case (p)
                8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83,
                8'd86, 8'd118, 8'd128, 8'd138, 8'd144: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void next_list();
            list_idx++;
            if (list_idx < ((chroma == 3) ? 12 : 8)) want_fixed(S_LISTFLAG, 1);
            else want_ue(S_FRAMENUM);
        endfunction

        function void scale_step();
            if (scale_next == 0 || loop_cnt == 0) next_list();
            else want_ue(S_DELTA);
        endfunction

        function void past_vcl();
            if (hrd[1:0] != 0) want_fixed(S_LOWDELAY, 1);
            else want_fixed(S_TAIL2, 2);
        endfunction

        // One syntax element has been read completely.
        function void element_done(logic [31:0] v);
            logic [31:0] d;
            case (step)
                S_PROFILE: begin profile = v[7:0]; want_fixed(S_CONSTR, 8); end
                S_CONSTR: begin constr = v[7:0]; want_fixed(S_LEVEL, 8); end
                S_LEVEL: begin level = v[7:0]; want_ue(S_SPSID); end
                S_SPSID: begin
                    set_id = v;
                    if (high_profile(profile[7:0])) want_ue(S_CHROMA);
                    else want_ue(S_FRAMENUM);
                end
                S_CHROMA: begin
                    chroma = v;
                    if (v == 3) want_fixed(S_SEPPLANE, 1); else want_ue(S_DEPTHL);
                end
                S_SEPPLANE: want_ue(S_DEPTHL);
                S_DEPTHL: begin luma8 = v; want_ue(S_DEPTHC); end
                S_DEPTHC: begin chroma8 = v; want_fixed(S_BYPASS, 1); end
                S_BYPASS: want_fixed(S_SMPRESENT, 1);
                S_SMPRESENT: begin
                    if (v != 0) begin
                        list_idx = 0; want_fixed(S_LISTFLAG, 1);
                    end else want_ue(S_FRAMENUM);
                end
                S_LISTFLAG: begin
                    if (v != 0) begin
                        loop_cnt = (list_idx < 6) ? 16 : 64;
                        scale_last = 8; scale_next = 8;
                        scale_step();
                    end else next_list();
                end
                S_DELTA: begin
                    d = v[0] ? (v >> 1) + 1 : 32'd0 - (v >> 1);
                    scale_next = scale_last + d[7:0];
                    if (scale_next != 0) scale_last = scale_next;
                    loop_cnt--;
                    scale_step();
                end
                S_FRAMENUM: begin frame_num = v; want_ue(S_POCTYPE); end
                S_POCTYPE: begin
                    poc = v;
                    if (v == 0) want_ue(S_POCLSB);
                    else if (v == 1) want_fixed(S_DZERO, 1);
                    else if (v == 2) want_ue(S_NUMREF);
                    else failed = ST_POC;
                end
                S_POCLSB: want_ue(S_NUMREF);
                S_DZERO: want_ue(S_OFFNR);
                S_OFFNR: want_ue(S_OFFTB);
                S_OFFTB: want_ue(S_CYCLE);
                S_CYCLE: begin
                    loop_cnt = v;
                    if (v == 0) want_ue(S_NUMREF); else want_ue(S_OFFREF);
                end
                S_OFFREF: begin
                    loop_cnt--;
                    if (loop_cnt == 0) want_ue(S_NUMREF); else want_ue(S_OFFREF);
                end
                S_NUMREF: want_fixed(S_GAPS, 1);
                S_GAPS: want_ue(S_WIDTH);
                S_WIDTH: begin width = v; want_ue(S_HEIGHT); end
                S_HEIGHT: begin height = v; want_fixed(S_FMO, 1); end
                S_FMO: begin
                    fmo = v & 1;
                    if (v[0]) want_fixed(S_DIRECT, 1); else want_fixed(S_MBAFF, 1);
                end
                S_MBAFF: want_fixed(S_DIRECT, 1);
                S_DIRECT: want_fixed(S_CROPFLAG, 1);
                S_CROPFLAG: if (v != 0) want_ue(S_CL); else want_fixed(S_VUIFLAG, 1);
                S_CL: begin crop_l = v; want_ue(S_CR); end
                S_CR: begin crop_r = v; want_ue(S_CT); end
                S_CT: begin crop_t = v; want_ue(S_CB); end
                S_CB: begin crop_b = v; want_fixed(S_VUIFLAG, 1); end
                S_VUIFLAG: if (v != 0) want_fixed(S_ARFLAG, 1); else step = S_DONE;
                S_ARFLAG: if (v != 0) want_fixed(S_ARIDC, 8); else want_fixed(S_OVFLAG, 1);
                S_ARIDC: begin
                    if (v[7:0] == SAR_EXTENDED) want_fixed(S_SAR, 32);
                    else want_fixed(S_OVFLAG, 1);
                end
                S_SAR: want_fixed(S_OVFLAG, 1);
                S_OVFLAG: if (v != 0) want_fixed(S_OVAPPR, 1); else want_fixed(S_VSTFLAG, 1);
                S_OVAPPR: want_fixed(S_VSTFLAG, 1);
                S_VSTFLAG: if (v != 0) want_fixed(S_VFMT, 4); else want_fixed(S_CLFLAG, 1);
                S_VFMT: want_fixed(S_CDFLAG, 1);
                S_CDFLAG: if (v != 0) want_fixed(S_CD, 24); else want_fixed(S_CLFLAG, 1);
                S_CD: want_fixed(S_CLFLAG, 1);
                S_CLFLAG: if (v != 0) want_ue(S_CLT); else want_fixed(S_TIMFLAG, 1);
                S_CLT: want_ue(S_CLB);
                S_CLB: want_fixed(S_TIMFLAG, 1);
                S_TIMFLAG: if (v != 0) want_fixed(S_TIM, 65); else want_fixed(S_NALFLAG, 1);
                S_TIM: want_fixed(S_NALFLAG, 1);
                S_NALFLAG: begin
                    if (v != 0) begin
                        hrd[0] = 1'b1; want_ue(S_HCNT);
                    end else want_fixed(S_VCLFLAG, 1);
                end
                S_VCLFLAG: begin
                    if (v != 0) begin
                        hrd[2:1] = 2'b11; want_ue(S_HCNT);
                    end else past_vcl();
                end
                S_HCNT: begin loop_cnt = v + 1; want_fixed(S_HSCALE, 8); end
                S_HSCALE: want_ue(S_HBR);
                S_HBR: want_ue(S_HCS);
                S_HCS: want_fixed(S_HCBR, 1);
                S_HCBR: begin
                    loop_cnt--;
                    if (loop_cnt != 0) want_ue(S_HBR); else want_fixed(S_HTAIL, 20);
                end
                S_HTAIL: if (hrd[2]) past_vcl(); else want_fixed(S_VCLFLAG, 1);
                S_LOWDELAY: want_fixed(S_TAIL2, 2);
                default: step = S_DONE;
            endcase
        endfunction

        function void take_bit(bit b);
            if (step == S_DONE || failed != ST_OK) return;
            if (rd_kind == RD_FIX) begin
                acc = {acc[30:0], b};
                rd_left--;
                if (rd_left == 0) element_done(acc);
            end else if (rd_kind == RD_PRE) begin
                if (!b) begin
                    zeros++;
                    if (zeros >= 32) failed = ST_BITS;
                end else if (zeros == 0) begin
                    element_done(32'd0);
                end else begin
                    rd_kind = RD_SUF; rd_left = zeros; acc = 0;
                end
            end else begin
                acc = {acc[30:0], b};
                rd_left--;
                if (rd_left == 0) element_done(((32'd1 << zeros) - 32'd1) + acc);
            end
        endfunction

        // Called for every accepted input item.
        function void note_byte(logic [7:0] b, bit last);
            bit          header;
            logic [31:0] cw, ch, cx, cy, crw, crh;
            t_sps_result r;
            header = (byte_count == 0);
            if (byte_count < 4) byte_count++;
            if (zero_run >= 2 && b == EP_BYTE) begin
                zero_run = 0;
            end else begin
                if (b == 0) begin
                    if (zero_run < 2) zero_run++;
                end else zero_run = 0;
                if (!header) for (int i = 7; i >= 0; i--) take_bit(b[i]);
            end
            if (!last) return;
            cw = (width + 1) * 16;
            ch = (32'd2 - fmo) * (height + 1) * 16;
            cx = (chroma == 0 || chroma == 3) ? 1 : 2;
            cy = (fmo != 0) ? 1 : 2;
            if (chroma == 1) cy = cy * 2;
            crw = (crop_l + crop_r) * cx;
            crh = (crop_t + crop_b) * cy;
            if (byte_count < 4) r.status = ST_SHORT;
            else if (failed != ST_OK) r.status = t_status'(failed);
            else if (step != S_DONE) r.status = ST_BITS;
            else if (crw >= cw || crh >= ch) r.status = ST_CROP;
            else r.status = ST_OK;
            foreach (r.vals[i]) r.vals[i] = 0;
            if (r.status == ST_OK) begin
                r.vals = '{profile, constr, level, set_id, chroma, (luma8 + 8) & 255,
                           (chroma8 + 8) & 255, poc & 3, frame_num, cw - crw, ch - crh};
            end
            pending.push_back(r);
            start_payload();
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d", what, want, got);
        endfunction

        // Called for every accepted result item.
        function void check_result(logic [207:0] d, logic [7:0] u);
            t_sps_result r;
            logic [31:0] got;
            if (pending.size() == 0) begin
                report("unexpected result, status", 0, u[2:0]);
                return;
            end
            r = pending.pop_front();
            status_seen[r.status]++;
            if (u !== {5'd0, r.status}) report("status", r.status, u);
            for (int i = 0; i < 11; i++) begin
                got = (d >> FIELD_LO[i]) & ((64'd1 << FIELD_W[i]) - 1);
                if (got !== r.vals[i]) report(FIELD_NAME[i], r.vals[i], got);
            end
            if (d[207:202] !== '0) report("tdata zero fill", 0, d[207:202]);
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [7:0]   i_s_tdata = '0;
    logic         i_s_tlast = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [207:0] o_m_tdata;
    logic [7:0]   o_m_tuser;
    logic         i_m_tready = 1'b0;

    h264_sps_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_m_tready (i_m_tready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sps_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned bytes_sent     = 0;
    int unsigned payloads_sent  = 0;

    // The receiver changes its ready only at rising edges, with the
    // current stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n) i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Outputs and ready are stable between edges, so sampling at the falling
    // edge sees exactly what the next rising edge accepts.
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    // Bits of the SPS under construction, MSB first.
    bit         rbsp_bits[$];
    logic [7:0] payload[$];

    task automatic put_bits(logic [31:0] v, int unsigned n);
        for (int i = n - 1; i >= 0; i--) rbsp_bits.push_back(v[i]);
    endtask

    task automatic put_ue(logic [31:0] v);
        logic [32:0] code;
        int          msb;
        code = {1'b0, v} + 33'd1;
        msb = 0;
        for (int i = 0; i < 33; i++) if (code[i]) msb = i;
        repeat (msb) rbsp_bits.push_back(1'b0);
        for (int i = msb; i >= 0; i--) rbsp_bits.push_back(code[i]);
    endtask

    // Mostly small values, now and then an extreme one.
    function automatic logic [31:0] pick_ue(int unsigned hi);
        case ($urandom_range(19))
            0: return 32'hFFFF_FFFE;
            1: return $urandom();
            default: return $urandom_range(hi);
        endcase
    endfunction

    task automatic put_hrd();
        int unsigned cnt;
        cnt = $urandom_range(2);
        put_ue(cnt);
        put_bits($urandom(), 8);
        repeat (cnt + 1) begin
            put_ue(pick_ue(50));
            put_ue(pick_ue(50));
            put_bits($urandom(), 1);
        end
        put_bits($urandom(), 20);
    endtask

    // Builds one SPS payload. Mode 0 is random; mode 1 forces a bad picture
    // order count type; mode 2 forces a crop as large as the picture.
    task automatic build_sps(int unsigned mode);
        logic [7:0]  prof;
        logic [7:0]  hi_ids[11] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 144};
        logic [31:0] chroma_fmt, poc_t, nflag, vflag;
        int unsigned nlists, zrun;
        rbsp_bits.delete();
        payload.delete();
        prof = ($urandom_range(1)) ? hi_ids[$urandom_range(10)] : 8'($urandom());
        put_bits(prof, 8);
        put_bits($urandom(), 8);
        put_bits($urandom(), 8);
        put_ue(pick_ue(31));
        chroma_fmt = 1;
        if (prof inside {100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 144}) begin
            chroma_fmt = $urandom_range(3);
            put_ue(chroma_fmt);
            if (chroma_fmt == 3) put_bits($urandom(), 1);
            put_ue(($urandom_range(9) == 0) ? 32'd250 : $urandom_range(6));
            put_ue(($urandom_range(9) == 0) ? 32'd248 : $urandom_range(6));
            put_bits($urandom(), 1);
            if ($urandom_range(2) == 0) begin
                put_bits(1, 1);
                nlists = (chroma_fmt == 3) ? 12 : 8;
                for (int l = 0; l < nlists; l++) begin
                    if ($urandom_range(3) == 0) begin
                        put_bits(1, 1);
                        // Deltas until the list ends; now and then they stop early after a large one.
                        repeat ((l < 6) ? 16 : 64) begin
                            if ($urandom_range(9) == 0) begin
                                put_ue($urandom_range(511));
                                break;
                            end
                            put_ue($urandom_range(3));
                        end
                    end else put_bits(0, 1);
                end
            end else put_bits(0, 1);
        end
        put_ue(pick_ue(12));
        poc_t = (mode == 1) ? 3 + $urandom_range(5) :
                ($urandom_range(19) == 0) ? pick_ue(9) : $urandom_range(2);
        put_ue(poc_t);
        if (poc_t == 0) put_ue(pick_ue(12));
        else if (poc_t == 1) begin
            put_bits($urandom(), 1);
            put_ue(pick_ue(40));
            put_ue(pick_ue(40));
            zrun = $urandom_range(3);
            put_ue(zrun);
            repeat (zrun) put_ue(pick_ue(40));
        end
        put_ue(pick_ue(16));
        put_bits($urandom(), 1);
        put_ue(($urandom_range(9) == 0) ? pick_ue(10) : $urandom_range(119));
        put_ue(($urandom_range(9) == 0) ? pick_ue(10) : $urandom_range(67));
        put_bits($urandom(), 1);
        if (rbsp_bits[$] == 1'b0) put_bits($urandom(), 1);
        put_bits($urandom(), 1);
        if (mode == 2) begin
            put_bits(1, 1);
            put_ue(32'h7FFF_FFFF); put_ue(32'h7FFF_FFFF);
            put_ue($urandom_range(3)); put_ue($urandom_range(3));
        end else if ($urandom_range(1)) begin
            put_bits(1, 1);
            repeat (4) put_ue(($urandom_range(7) == 0) ? pick_ue(200) : $urandom_range(5));
        end else put_bits(0, 1);
        if ($urandom_range(1)) begin
            put_bits(1, 1);
            if ($urandom_range(1)) begin
                put_bits(1, 1);
                if ($urandom_range(1)) begin
                    put_bits(SAR_EXTENDED, 8); put_bits($urandom(), 32);
                end else put_bits($urandom_range(254), 8);
            end else put_bits(0, 1);
            if ($urandom_range(1)) begin put_bits(1, 1); put_bits($urandom(), 1); end
            else put_bits(0, 1);
            if ($urandom_range(1)) begin
                put_bits(1, 1); put_bits($urandom(), 4);
                if ($urandom_range(1)) begin put_bits(1, 1); put_bits($urandom(), 24); end
                else put_bits(0, 1);
            end else put_bits(0, 1);
            if ($urandom_range(1)) begin
                put_bits(1, 1); put_ue(pick_ue(5)); put_ue(pick_ue(5));
            end else put_bits(0, 1);
            if ($urandom_range(1)) begin
                put_bits(1, 1); put_bits($urandom(), 32); put_bits($urandom(), 32);
                put_bits($urandom(), 1);
            end else put_bits(0, 1);
            nflag = $urandom_range(1);
            put_bits(nflag, 1);
            if (nflag != 0) put_hrd();
            vflag = $urandom_range(1);
            put_bits(vflag, 1);
            if (vflag != 0) put_hrd();
            if (nflag != 0 || vflag != 0) put_bits($urandom(), 1);
            put_bits($urandom(), 2);
        end else put_bits(0, 1);
        // Stop bit and byte alignment.
        put_bits(1, 1);
        while (rbsp_bits.size() % 8 != 0) rbsp_bits.push_back(1'b0);
        if (mode == 0 && $urandom_range(9) == 0)
            rbsp_bits[$urandom_range(rbsp_bits.size() - 1)] ^= 1'b1;
        if (mode == 0 && $urandom_range(9) == 0)
            repeat ($urandom_range(1, rbsp_bits.size() / 8 - 1))
                repeat (8) void'(rbsp_bits.pop_back());
        if (mode == 0 && $urandom_range(9) == 0)
            repeat ($urandom_range(1, 3) * 8) rbsp_bits.push_back($urandom_range(1));
        // Header byte, then the payload with emulation prevention.
        payload.push_back(($urandom_range(3) == 0) ? 8'($urandom()) : 8'h67);
        zrun = 0;
        for (int i = 0; i < rbsp_bits.size(); i += 8) begin
            logic [7:0] b;
            for (int k = 0; k < 8; k++) b[7 - k] = rbsp_bits[i + k];
            if (zrun >= 2 && b <= 8'h03) begin
                payload.push_back(EP_BYTE);
                zrun = 0;
            end
            payload.push_back(b);
            zrun = (b == 0) ? zrun + 1 : 0;
        end
    endtask

    // Random bytes, leaning on zeros and on the emulation-prevention byte.
    task automatic build_noise();
        payload.delete();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(3))
                0: payload.push_back(8'h00);
                1: payload.push_back(EP_BYTE);
                default: payload.push_back(8'($urandom()));
            endcase
        end
    endtask

    // Sends one item and returns at the edge that accepts it.
    task automatic send_byte(logic [7:0] b, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_payload();
        foreach (payload[i]) send_byte(payload[i], i == payload.size() - 1);
        payloads_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        payload = bytes;
        send_payload();
    endtask

    // Lets every expected result drain before the sender goes on.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("[h264_sps_parser] ERROR");
        $finish;
    end

    initial begin
        int unsigned idle_tab[4]  = '{0, 52, 0, 21};
        int unsigned stall_tab[4] = '{0, 0, 52, 21};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a lone header byte, three raw bytes with a dropped
        // emulation-prevention byte, an Exp-Golomb prefix of 32 zeros, a bad
        // picture order count type and a crop as large as the picture.
        send_bytes('{8'hFF});
        send_bytes('{8'h00, 8'h00, 8'h03});
        send_bytes('{8'h67, 8'h42, 8'hFF, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
        build_sps(1);
        send_payload();
        build_sps(2);
        send_payload();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            while (bytes_sent < 350 * (ph + 1)) begin
                if ($urandom_range(9) < 7) build_sps(0);
                else build_noise();
                send_payload();
            end
            drain();
        end

        i_s_tvalid <= 1'b0;
        repeat (50) @(posedge i_clk);
        $display("covered %0d payloads, %0d bytes; status ok %0d short %0d bits %0d",
                 payloads_sent, bytes_sent, sb.status_seen[ST_OK], sb.status_seen[ST_SHORT],
                 sb.status_seen[ST_BITS]);
        $display("bad poc type %0d, bad crop %0d, under four idle/stall mixes",
                 sb.status_seen[ST_POC], sb.status_seen[ST_CROP]);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[h264_sps_parser] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("[h264_sps_parser] ERROR");
        end
        $finish;
    end

endmodule
